### rtl/core/rsbt_pkg.sv
// Shared types and helpers for the record sorter.
`timescale 1ns / 1ps
package rsbt_pkg;

  localparam int MaxRecordsDef = 64;
  localparam int KeyW          = 24;

  typedef struct packed {
    logic [7:0]  minutes;
    logic [5:0]  seconds;
    logic [9:0]  millis;
    logic [9:0]  peak_rate;
    logic [15:0] tag;
  } rec_t;

  typedef struct packed {
    logic ins;
    logic ovf;
    logic pop;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic one_left;
  } sts_t;

  function automatic logic [KeyW-1:0] rsbt_key(input rec_t r);
    rsbt_key = {r.minutes, r.seconds, r.millis};
  endfunction

endpackage

### rtl/core/rsbt_if.sv
// Valid/ready channel interfaces for record input and sorted output items.
`timescale 1ns / 1ps
interface rsbt_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  minutes;
  logic [5:0]  seconds;
  logic [9:0]  millis;
  logic [9:0]  peak_rate;
  logic [15:0] record_tag;
  logic        last_in;

  modport source (output valid, minutes, seconds, millis, peak_rate, record_tag, last_in,
                  input ready);
  modport sink (input valid, minutes, seconds, millis, peak_rate, record_tag, last_in,
                output ready);
endinterface

interface rsbt_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_minutes;
  logic [5:0]  out_seconds;
  logic [9:0]  out_millis;
  logic [9:0]  out_peak_rate;
  logic [15:0] out_tag;
  logic        last_out;
  logic        overflowed;

  modport source (output valid, out_minutes, out_seconds, out_millis, out_peak_rate,
                  out_tag, last_out, overflowed, input ready);
  modport sink (input valid, out_minutes, out_seconds, out_millis, out_peak_rate,
                out_tag, last_out, overflowed, output ready);
endinterface

### rtl/core/rsbt_dp.sv
// Datapath: sorted insertion chain of records, fill count and overflow flag.
`timescale 1ns / 1ps
module rsbt_dp #(
  parameter int MAX_RECORDS = rsbt_pkg::MaxRecordsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rsbt_pkg::cmd_t cmd_i,
  input  rsbt_pkg::rec_t new_rec_i,
  output rsbt_pkg::sts_t sts_o,
  output rsbt_pkg::rec_t head_rec_o,
  output logic          ovf_o
);
  import rsbt_pkg::*;

  localparam int CntW = $clog2(MAX_RECORDS + 1);

  rec_t            cell_q [MAX_RECORDS];
  rec_t            cell_d [MAX_RECORDS];
  logic [MAX_RECORDS-1:0] keep;
  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;

  // keep[i]: occupied cell whose key is not below the new key (prefix of the chain)
  always_comb begin
    for (int i = 0; i < MAX_RECORDS; i++) begin
      keep[i] = (CntW'(i) < count_q) && (rsbt_key(cell_q[i]) >= rsbt_key(new_rec_i));
    end
  end

  always_comb begin
    cell_d = cell_q;
    if (cmd_i.ins) begin
      if (!keep[0]) begin
        cell_d[0] = new_rec_i;
      end
      for (int i = 1; i < MAX_RECORDS; i++) begin
        if (keep[i]) begin
          cell_d[i] = cell_q[i];
        end else if (keep[i-1]) begin
          cell_d[i] = new_rec_i;
        end else begin
          cell_d[i] = cell_q[i-1];
        end
      end
    end else if (cmd_i.pop) begin
      for (int i = 0; i < MAX_RECORDS - 1; i++) begin
        cell_d[i] = cell_q[i+1];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (cmd_i.ins) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.pop) begin
      count_d = count_q - CntW'(1);
      if (sts_o.one_left) begin
        ovf_d = 1'b0;
      end
    end
    if (cmd_i.ovf) begin
      ovf_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  assign sts_o.full     = (count_q == CntW'(MAX_RECORDS));
  assign sts_o.one_left = (count_q == CntW'(1));
  assign head_rec_o     = cell_q[0];
  assign ovf_o          = ovf_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_RECORDS))
    else $error("record count above capacity");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> count_q != '0)
    else $error("pop from empty store");

  a_drain_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pop && sts_o.one_left) |=> (count_q == '0 && !ovf_q))
    else $error("store not empty after final pop");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q > CntW'(1)) |-> rsbt_key(cell_q[0]) >= rsbt_key(cell_q[1]))
    else $error("chain head out of order");

endmodule

### rtl/core/rsbt_ctrl.sv
// Controller: load phase takes records, emit phase drains the sorted chain.
`timescale 1ns / 1ps
module rsbt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_last_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  rsbt_pkg::sts_t sts_i,
  output rsbt_pkg::cmd_t cmd_o
);
  import rsbt_pkg::*;

  typedef enum logic {
    StLoad,
    StEmit
  } state_e;

  state_e state_q;
  logic   in_ready_q, out_valid_q;
  logic   in_fire, out_fire;

  assign in_fire  = in_valid_i && in_ready_q;
  assign out_fire = out_valid_q && out_ready_i;

  assign cmd_o.ins = in_fire && !sts_i.full;
  assign cmd_o.ovf = in_fire && sts_i.full;
  assign cmd_o.pop = out_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        StLoad: begin
          if (in_fire && in_last_i) begin
            state_q     <= StEmit;
            in_ready_q  <= 1'b0;
            out_valid_q <= 1'b1;
          end
        end
        StEmit: begin
          if (out_fire && sts_i.one_left) begin
            state_q     <= StLoad;
            in_ready_q  <= 1'b1;
            out_valid_q <= 1'b0;
          end
        end
        default: begin
          state_q     <= StLoad;
          in_ready_q  <= 1'b1;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

### rtl/core/record_sort_by_time_desc_core.sv
// Load phase: one record item per cycle, placed in sorted position as it arrives.
// After the last item, results start on the next cycle, one per cycle while
// the sink is ready, until the store is empty; input is held off meanwhile.
// The store is a sorted insertion chain of MAX_RECORDS registers.
// Reset (asynchronous, active low) empties the store and clears the overflow flag.
`timescale 1ns / 1ps
module record_sort_by_time_desc_core #(
  parameter int MAX_RECORDS = rsbt_pkg::MaxRecordsDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  rsbt_in_if.sink rec_in_i,
  rsbt_out_if.source rec_out_o
);
  import rsbt_pkg::*;

  cmd_t cmd;
  sts_t sts;
  rec_t new_rec;
  rec_t head_rec;
  logic ovf;

  assign new_rec.minutes   = rec_in_i.minutes;
  assign new_rec.seconds   = rec_in_i.seconds;
  assign new_rec.millis    = rec_in_i.millis;
  assign new_rec.peak_rate = rec_in_i.peak_rate;
  assign new_rec.tag       = rec_in_i.record_tag;

  rsbt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rec_in_i.valid),
    .in_last_i  (rec_in_i.last_in),
    .in_ready_o (rec_in_i.ready),
    .out_valid_o(rec_out_o.valid),
    .out_ready_i(rec_out_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rsbt_dp #(
    .MAX_RECORDS(MAX_RECORDS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .new_rec_i (new_rec),
    .sts_o     (sts),
    .head_rec_o(head_rec),
    .ovf_o     (ovf)
  );

  assign rec_out_o.out_minutes   = head_rec.minutes;
  assign rec_out_o.out_seconds   = head_rec.seconds;
  assign rec_out_o.out_millis    = head_rec.millis;
  assign rec_out_o.out_peak_rate = head_rec.peak_rate;
  assign rec_out_o.out_tag       = head_rec.tag;
  assign rec_out_o.last_out      = sts.one_left;
  assign rec_out_o.overflowed    = ovf;

endmodule
